@@ sv/stp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package stp_pkg;

   // field widths
   localparam int YAW_W   = 16;
   localparam int SUM_W   = 18;
   localparam int SPEED_W = 14;
   localparam int OUT_W   = 15;
   localparam int ANGLE_W = 16;
   localparam int CFG_W   = 16;
   localparam int IDX_W   = 3;

   // divider: magnitude of span * num stays below 2^30
   localparam int PROD_W    = 30;
   localparam int DIV_STEPS = PROD_W;
   localparam int CNT_W     = 5;

   // register indexes
   localparam logic [IDX_W-1:0] REG_FULL_SPEED  = 3'd0;
   localparam logic [IDX_W-1:0] REG_MIN_SPEED   = 3'd1;
   localparam logic [IDX_W-1:0] REG_ACCEL_END   = 3'd2;
   localparam logic [IDX_W-1:0] REG_DECEL_START = 3'd3;
   localparam logic [IDX_W-1:0] REG_STOP_ANGLE  = 3'd4;

   // register reset values
   localparam logic [SPEED_W-1:0] FULL_SPEED_RST  = 14'd2500;
   localparam logic [SPEED_W-1:0] MIN_SPEED_RST   = 14'd800;
   localparam logic [ANGLE_W-1:0] ACCEL_END_RST   = 16'd3000;
   localparam logic [ANGLE_W-1:0] DECEL_START_RST = 16'd30000;
   localparam logic [ANGLE_W-1:0] STOP_ANGLE_RST  = 16'd35800;

   // angle and speed constants
   localparam logic signed [SUM_W-1:0] HALF_TURN     = 18'sd18000;
   localparam logic signed [SUM_W-1:0] NEG_HALF_TURN = -18'sd18000;
   localparam logic signed [SUM_W-1:0] FULL_TURN     = 18'sd36000;
   localparam logic signed [SUM_W-1:0] SUM_MAX       = 18'sd131071;
   localparam logic signed [SUM_W-1:0] SUM_MIN       = -18'sd131072;
   localparam logic [SPEED_W-1:0]      SPEED_LIMIT   = 14'd10000;

   // speed source for the result
   localparam logic [1:0] MODE_ZERO = 2'd0;
   localparam logic [1:0] MODE_FULL = 2'd1;
   localparam logic [1:0] MODE_RAMP = 2'd2;

   typedef struct packed {
      logic cap;        // capture the accepted input
      logic sum_en;     // update yaw and accumulator
      logic class_en;   // classify turned angle, pick ramp operands
      logic mul_en;     // form product and load divider
      logic div_step;   // one restoring division step
      logic out_load;   // load result register
   } cmd_type;

   typedef struct packed {
      logic calc;       // sample taken while armed
      logic need_div;   // turned angle lies on a ramp
   } status_type;

endpackage

`default_nettype wire

@@ sv/stp_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module stp_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   input  wire stp_pkg::status_type status,
   output stp_pkg::cmd_type       cmd
);
   import stp_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SUM   = 3'd1;
   localparam logic [2:0] S_CLASS = 3'd2;
   localparam logic [2:0] S_MUL   = 3'd3;
   localparam logic [2:0] S_DIV   = 3'd4;
   localparam logic [2:0] S_OUT   = 3'd5;

   logic [2:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      case (state_ff)
         S_IDLE: begin
            cmd.cap = req_valid;
            if (req_valid) begin
               state_in = S_SUM;
            end
         end
         S_SUM: begin
            cmd.sum_en = 1'b1;
            state_in   = status.calc ? S_CLASS : S_OUT;
         end
         S_CLASS: begin
            cmd.class_en = 1'b1;
            state_in     = status.need_div ? S_MUL : S_OUT;
         end
         S_MUL: begin
            cmd.mul_en = 1'b1;
            cnt_in     = CNT_W'(DIV_STEPS - 1);
            state_in   = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            // hold until the result register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

@@ sv/stp_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none

module stp_datapath (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_we,
   input  wire logic [stp_pkg::IDX_W-1:0]            csr_index,
   input  wire logic [stp_pkg::CFG_W-1:0]            csr_wdata,
   input  wire logic                                 req_cmd,
   input  wire logic signed [stp_pkg::YAW_W-1:0]     req_yaw,
   input  wire stp_pkg::cmd_type                     cmd,
   output stp_pkg::status_type                       status,
   output logic signed [stp_pkg::OUT_W-1:0]          rsp_left_speed,
   output logic signed [stp_pkg::OUT_W-1:0]          rsp_right_speed,
   output logic                                      rsp_done_res,
   output logic                                      rsp_active
);
   import stp_pkg::*;

   // configuration
   logic [SPEED_W-1:0] full_speed_ff, min_speed_ff;
   logic [ANGLE_W-1:0] accel_end_ff, decel_start_ff, stop_angle_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         full_speed_ff  <= FULL_SPEED_RST;
         min_speed_ff   <= MIN_SPEED_RST;
         accel_end_ff   <= ACCEL_END_RST;
         decel_start_ff <= DECEL_START_RST;
         stop_angle_ff  <= STOP_ANGLE_RST;
      end else if (csr_we) begin
         case (csr_index)
            REG_FULL_SPEED:  full_speed_ff  <= csr_wdata[SPEED_W-1:0];
            REG_MIN_SPEED:   min_speed_ff   <= csr_wdata[SPEED_W-1:0];
            REG_ACCEL_END:   accel_end_ff   <= csr_wdata;
            REG_DECEL_START: decel_start_ff <= csr_wdata;
            REG_STOP_ANGLE:  stop_angle_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // captured item
   logic                    cmd_ff;
   logic signed [YAW_W-1:0] yaw_ff;

   always_ff @(posedge clock) begin
      if (cmd.cap) begin
         cmd_ff <= req_cmd;
         yaw_ff <= req_yaw;
      end
   end

   // spin state
   logic signed [YAW_W-1:0] prev_yaw_ff;
   logic signed [SUM_W-1:0] sum_ff;
   logic                    armed_ff;
   logic                    done_ff;
   logic [1:0]              mode_ff;

   logic signed [SUM_W-1:0] delta, delta_a, delta_b;
   logic signed [SUM_W:0]   sum_wide;
   logic signed [SUM_W-1:0] sum_sat;

   always_comb begin
      delta   = SUM_W'(yaw_ff) - SUM_W'(prev_yaw_ff);
      delta_a = (delta > HALF_TURN) ? delta - FULL_TURN : delta;
      delta_b = (delta_a < NEG_HALF_TURN) ? delta_a + FULL_TURN : delta_a;
      sum_wide = (SUM_W+1)'(sum_ff) + (SUM_W+1)'(delta_b);
      if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
         sum_sat = sum_wide[SUM_W] ? SUM_MIN : SUM_MAX;
      end else begin
         sum_sat = sum_wide[SUM_W-1:0];
      end
   end

   // classification of the turned angle
   logic [SUM_W-1:0] turned;
   logic             at_stop, in_accel, in_decel;

   always_comb begin
      turned   = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
      at_stop  = (turned >= SUM_W'(stop_angle_ff));
      in_accel = (turned < SUM_W'(accel_end_ff));
      in_decel = (turned >= SUM_W'(decel_start_ff));
   end

   assign status.calc     = cmd_ff & armed_ff;
   assign status.need_div = !at_stop && (in_accel || in_decel);

   // ramp operands, product, divider
   logic [ANGLE_W-1:0] num_ff, den_ff;
   logic [ANGLE_W-1:0] rem_ff;
   logic [PROD_W-1:0]  quo_ff;
   logic               neg_ff;
   logic [SPEED_W-1:0] span_mag;
   logic [ANGLE_W:0]   shifted, trial;

   always_comb begin
      span_mag = (full_speed_ff >= min_speed_ff) ? full_speed_ff - min_speed_ff
                                                 : min_speed_ff - full_speed_ff;
      shifted  = {rem_ff, quo_ff[PROD_W-1]};
      trial    = shifted - {1'b0, den_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_yaw_ff <= '0;
         sum_ff      <= '0;
         armed_ff    <= 1'b0;
      end else if (cmd.sum_en) begin
         if (!cmd_ff) begin
            prev_yaw_ff <= yaw_ff;
            sum_ff      <= '0;
            armed_ff    <= 1'b1;
         end else if (armed_ff) begin
            prev_yaw_ff <= yaw_ff;
            sum_ff      <= sum_sat;
         end
      end else if (cmd.class_en && at_stop) begin
         armed_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.sum_en) begin
         done_ff <= 1'b0;
         mode_ff <= MODE_ZERO;
      end
      if (cmd.class_en) begin
         if (at_stop) begin
            done_ff <= 1'b1;
            mode_ff <= MODE_ZERO;
         end else if (in_accel) begin
            mode_ff <= MODE_RAMP;
            num_ff  <= turned[ANGLE_W-1:0];
            den_ff  <= accel_end_ff;
         end else if (!in_decel) begin
            mode_ff <= MODE_FULL;
         end else begin
            mode_ff <= MODE_RAMP;
            num_ff  <= stop_angle_ff - turned[ANGLE_W-1:0];
            den_ff  <= stop_angle_ff - decel_start_ff;
         end
      end
      if (cmd.mul_en) begin
         neg_ff <= (full_speed_ff < min_speed_ff);
         quo_ff <= PROD_W'(span_mag) * PROD_W'(num_ff);
         rem_ff <= '0;
      end
      if (cmd.div_step) begin
         if (!trial[ANGLE_W]) begin
            rem_ff <= trial[ANGLE_W-1:0];
            quo_ff <= {quo_ff[PROD_W-2:0], 1'b1};
         end else begin
            rem_ff <= shifted[ANGLE_W-1:0];
            quo_ff <= {quo_ff[PROD_W-2:0], 1'b0};
         end
      end
   end

   // final speed and result register
   logic signed [SPEED_W+2:0] ramp_sum;
   logic [SPEED_W-1:0]        speed;
   logic signed [OUT_W-1:0]   left_in;

   always_comb begin
      ramp_sum = neg_ff ? $signed({3'b000, min_speed_ff}) - $signed({3'b000, quo_ff[SPEED_W-1:0]})
                        : $signed({3'b000, min_speed_ff}) + $signed({3'b000, quo_ff[SPEED_W-1:0]});
      case (mode_ff)
         MODE_FULL: speed = (full_speed_ff > SPEED_LIMIT) ? SPEED_LIMIT : full_speed_ff;
         MODE_RAMP: begin
            if (ramp_sum[SPEED_W+2]) begin
               speed = '0;
            end else if (ramp_sum > $signed({3'b000, SPEED_LIMIT})) begin
               speed = SPEED_LIMIT;
            end else begin
               speed = ramp_sum[SPEED_W-1:0];
            end
         end
         default: speed = '0;
      endcase
      left_in = $signed({1'b0, speed});
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_left_speed  <= left_in;
         rsp_right_speed <= -left_in;
         rsp_done_res    <= done_ff;
         rsp_active      <= armed_ff;
      end
   end

endmodule

`default_nettype wire

@@ sv/spin_trapezoid_profile.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Trapezoidal wheel-speed generator for one in-place spin. Send a start item
// (req_cmd 0) to latch the yaw and arm; then send one sample item (req_cmd 1)
// per yaw reading. Every item gives exactly one result: left = +speed,
// right = -speed, plus done and active flags. Angles are hundredths of a
// degree, speeds hundredths of a speed unit. Steps: a start item or a sample
// while disarmed passes the sum and output states; a stop or cruise sample
// passes sum, classify and output; a sample on either ramp also passes the
// multiply state and the 30-step restoring divider (one quotient bit per
// cycle) that scales the ramp. The input is free again in the cycle after
// the load, so the block takes no new item before the last one is loaded.
// A new item is taken while the previous result still waits in the output
// register; a result stalls only when the output register is still full.
// Write configuration only while no item is in flight.

module spin_trapezoid_profile (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_we,
   input  wire logic [stp_pkg::IDX_W-1:0]        csr_index,
   input  wire logic [stp_pkg::CFG_W-1:0]        csr_wdata,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic                             req_cmd,
   input  wire logic signed [stp_pkg::YAW_W-1:0] req_yaw,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic signed [stp_pkg::OUT_W-1:0]      rsp_left_speed,
   output logic signed [stp_pkg::OUT_W-1:0]      rsp_right_speed,
   output logic                                  rsp_done_res,
   output logic                                  rsp_active
);
   import stp_pkg::*;

   // command and status between sequencer and datapath
   cmd_type    cmd;
   status_type status;

   // sequencer: capture, accumulate, classify, multiply, divide, load result
   stp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: config registers, spin state, ramp arithmetic, result register
   stp_datapath u_dp (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_cmd         (req_cmd),
      .req_yaw         (req_yaw),
      .cmd             (cmd),
      .status          (status),
      .rsp_left_speed  (rsp_left_speed),
      .rsp_right_speed (rsp_right_speed),
      .rsp_done_res    (rsp_done_res),
      .rsp_active      (rsp_active)
   );

endmodule

`default_nettype wire

@@ sv/stp_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module stp_checker (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             rsp_valid,
   input wire logic                             rsp_stall,
   input wire logic signed [stp_pkg::OUT_W-1:0] rsp_left_speed,
   input wire logic signed [stp_pkg::OUT_W-1:0] rsp_right_speed,
   input wire logic                             rsp_done_res,
   input wire logic                             rsp_active
);
   import stp_pkg::*;

   // right wheel mirrors left
   a_mirror: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_right_speed == -rsp_left_speed))
      else $error("right speed is not the negative of left speed");

   // completed spin leaves the block disarmed at zero speed
   a_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_done_res) |-> (!rsp_active && rsp_left_speed == '0))
      else $error("done result with speed or still armed");

   // speed stays in its clamp range
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_left_speed[OUT_W-1] &&
                     rsp_left_speed <= $signed({1'b0, SPEED_LIMIT})))
      else $error("left speed outside clamp range");

   // stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_left_speed) &&
                                    $stable(rsp_done_res) && $stable(rsp_active)))
      else $error("stalled result changed");

endmodule

bind spin_trapezoid_profile stp_checker u_stp_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_left_speed  (rsp_left_speed),
   .rsp_right_speed (rsp_right_speed),
   .rsp_done_res    (rsp_done_res),
   .rsp_active      (rsp_active)
);

`default_nettype wire

@@ dv/spin_trapezoid_profile_tb.sv @@
`timescale 1ns / 1ps

module spin_trapezoid_profile_tb;
   import stp_pkg::*;

   // item codes on req_cmd
   localparam logic CMD_START  = 1'b0;
   localparam logic CMD_SAMPLE = 1'b1;

   // ramp samples take longest; leave a margin before any register write
   localparam int SETTLE_CYCLES = 60;
   // long receiver hold-off used to fill the block and stall its input
   localparam int HOLD_CYCLES   = 400;

   typedef struct packed {
      logic [OUT_W-1:0] left;
      logic [OUT_W-1:0] right;
      logic             done;
      logic             active;
   } wheel_cmd_type;

   logic                    clock     = 1'b0;
   logic                    reset     = 1'b1;
   logic                    csr_we    = 1'b0;
   logic [IDX_W-1:0]        csr_index = '0;
   logic [CFG_W-1:0]        csr_wdata = '0;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic                    req_cmd   = CMD_START;
   logic signed [YAW_W-1:0] req_yaw   = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic signed [OUT_W-1:0] rsp_left_speed;
   logic signed [OUT_W-1:0] rsp_right_speed;
   logic                    rsp_done_res;
   logic                    rsp_active;

   // shadow copy of the profile registers, kept in step with every csr write
   logic [SPEED_W-1:0] prof_full  = FULL_SPEED_RST;
   logic [SPEED_W-1:0] prof_min   = MIN_SPEED_RST;
   logic [ANGLE_W-1:0] prof_accel = ACCEL_END_RST;
   logic [ANGLE_W-1:0] prof_decel = DECEL_START_RST;
   logic [ANGLE_W-1:0] prof_stop  = STOP_ANGLE_RST;

   // shadow copy of the spin state
   longint spin_prev  = 0;
   longint spin_sum   = 0;
   logic   spin_armed = 1'b0;

   // wheel commands predicted for accepted items, oldest first
   wheel_cmd_type wheels_due[$];

   int fail_count    = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_epoch    = 0;
   int hold_seen     = 0;
   int hold_left     = 0;

   spin_trapezoid_profile DUT (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cmd         (req_cmd),
      .req_yaw         (req_yaw),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_left_speed  (rsp_left_speed),
      .rsp_right_speed (rsp_right_speed),
      .rsp_done_res    (rsp_done_res),
      .rsp_active      (rsp_active)
   );

   always #5 clock = ~clock;

   // Advance the shadow spin state by one item and return the wheel command it gives.
   function automatic wheel_cmd_type predict_wheels(input logic cmd,
                                                    input logic signed [YAW_W-1:0] yaw);
      wheel_cmd_type res;
      longint        delta;
      longint        turned;
      longint        speed;
      longint        span;
      longint        neg_speed;
      speed    = 0;
      res.done = 1'b0;
      span     = longint'(prof_full) - longint'(prof_min);
      if (cmd == CMD_START) begin
         spin_prev  = longint'(yaw);
         spin_sum   = 0;
         spin_armed = 1'b1;
      end else if (spin_armed) begin
         delta     = longint'(yaw) - spin_prev;
         spin_prev = longint'(yaw);
         // wrap once only; a change of exactly a half turn stays as it is
         if (delta > longint'(HALF_TURN))
            delta -= longint'(FULL_TURN);
         if (delta < longint'(NEG_HALF_TURN))
            delta += longint'(FULL_TURN);
         spin_sum = spin_sum + delta;
         if (spin_sum > longint'(SUM_MAX))
            spin_sum = longint'(SUM_MAX);
         if (spin_sum < longint'(SUM_MIN))
            spin_sum = longint'(SUM_MIN);
         turned = (spin_sum < 0) ? -spin_sum : spin_sum;
         // stop wins over both ramps, so a zero stop angle ends on the first sample
         if (turned >= longint'(prof_stop)) begin
            spin_armed = 1'b0;
            res.done   = 1'b1;
         end else if (turned < longint'(prof_accel)) begin
            speed = longint'(prof_min) + (span * turned) / longint'(prof_accel);
         end else if (turned < longint'(prof_decel)) begin
            speed = longint'(prof_full);
         end else begin
            speed = longint'(prof_min) + (span * (longint'(prof_stop) - turned)) /
                    (longint'(prof_stop) - longint'(prof_decel));
         end
         if (speed < 0)
            speed = 0;
         if (speed > longint'(SPEED_LIMIT))
            speed = longint'(SPEED_LIMIT);
      end
      neg_speed  = -speed;
      res.left   = speed[OUT_W-1:0];
      res.right  = neg_speed[OUT_W-1:0];
      res.active = spin_armed;
      return res;
   endfunction

   // Offer one item after a random idle gap, hold it until the transfer, then
   // queue its prediction. Valid stays high on return so back-to-back items
   // never lower and raise it within one step.
   task automatic send_spin_item(input logic cmd, input logic signed [YAW_W-1:0] yaw);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct)
         gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd   <= cmd;
      req_yaw   <= yaw;
      do
         @(posedge clock);
      while (req_stall);
      wheels_due.push_back(predict_wheels(cmd, yaw));
   endtask

   // Drop valid, wait for every queued command to come back, then let the block settle.
   task automatic drain();
      req_valid <= 1'b0;
      while (wheels_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One register write; the caller lowers the write enable after its last write.
   task automatic write_reg(input logic [IDX_W-1:0] idx, input int value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[CFG_W-1:0];
      @(posedge clock);
      case (idx)
         REG_FULL_SPEED:  prof_full  = value[SPEED_W-1:0];
         REG_MIN_SPEED:   prof_min   = value[SPEED_W-1:0];
         REG_ACCEL_END:   prof_accel = value[ANGLE_W-1:0];
         REG_DECEL_START: prof_decel = value[ANGLE_W-1:0];
         REG_STOP_ANGLE:  prof_stop  = value[ANGLE_W-1:0];
         default: ;
      endcase
   endtask

   // Load a whole profile once the block has gone idle.
   task automatic apply_profile(input int full_v, input int min_v, input int accel_v,
                                input int decel_v, input int stop_v);
      drain();
      write_reg(REG_FULL_SPEED, full_v);
      write_reg(REG_MIN_SPEED, min_v);
      write_reg(REG_ACCEL_END, accel_v);
      write_reg(REG_DECEL_START, decel_v);
      write_reg(REG_STOP_ANGLE, stop_v);
      csr_we <= 1'b0;
   endtask

   function automatic int pick_speed();
      if ($urandom_range(3) == 0)
         return $urandom_range(1) ? 10000 : 0;
      return $urandom_range(0, 10000);
   endfunction

   // Draw a profile: the corners now and then, otherwise mostly ordered angles,
   // with short spins favored so that many spins complete.
   task automatic random_profile();
      int full_v, min_v, a, d, s;
      full_v = pick_speed();
      min_v  = pick_speed();
      case ($urandom_range(7))
         0: apply_profile(full_v, min_v, 1, 0, 1);
         1: apply_profile(full_v, min_v, 36000, 35999, 36000);
         default: begin
            s = ($urandom_range(2) == 0) ? $urandom_range(1, 36000) : $urandom_range(1, 4000);
            d = $urandom_range(0, s - 1);
            a = ($urandom_range(5) == 0) ? $urandom_range(1, 36000)
                                         : $urandom_range(1, (d > 0) ? d : 1);
            apply_profile(full_v, min_v, a, d, s);
         end
      endcase
   endtask

   // Receiver: check each transfer against the oldest prediction, then pick
   // the stall for the next cycle. A hold-off request runs out here, cycle by cycle.
   always @(posedge clock) begin
      wheel_cmd_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (wheels_due.size() == 0) begin
               $error("wheel command transfer with nothing predicted");
               fail_count++;
            end else begin
               want = wheels_due.pop_front();
               if (rsp_left_speed !== want.left) begin
                  $error("left_speed: expected %0d, got %0d",
                         $signed(want.left), rsp_left_speed);
                  fail_count++;
               end
               if (rsp_right_speed !== want.right) begin
                  $error("right_speed: expected %0d, got %0d",
                         $signed(want.right), rsp_right_speed);
                  fail_count++;
               end
               if (rsp_done_res !== want.done) begin
                  $error("done_res: expected %0d, got %0d", want.done, rsp_done_res);
                  fail_count++;
               end
               if (rsp_active !== want.active) begin
                  $error("active: expected %0d, got %0d", want.active, rsp_active);
                  fail_count++;
               end
            end
         end
         if (hold_epoch != hold_seen) begin
            hold_seen = hold_epoch;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         end
      end
   end

   // Reset profile: disarmed sample, up ramp, cruise, a wrap to zero change,
   // an exact half-turn change that hits the stop, then a sample after done.
   task automatic test_reset_profile();
      send_spin_item(CMD_SAMPLE, 16'sd1234);
      send_spin_item(CMD_START, 16'sd0);
      send_spin_item(CMD_SAMPLE, 16'sd1500);
      send_spin_item(CMD_SAMPLE, 16'sd18000);
      send_spin_item(CMD_SAMPLE, -16'sd18000);
      send_spin_item(CMD_SAMPLE, 16'sd0);
      send_spin_item(CMD_SAMPLE, 16'sd500);
   endtask

   // Down ramp from its exact start to the stop, then a turn the other way
   // that lands exactly on the end of the up ramp.
   task automatic test_down_ramp();
      send_spin_item(CMD_START, 16'sd0);
      send_spin_item(CMD_SAMPLE, 16'sd15000);
      send_spin_item(CMD_SAMPLE, -16'sd6000);
      send_spin_item(CMD_SAMPLE, -16'sd4200);
      send_spin_item(CMD_SAMPLE, -16'sd200);
      send_spin_item(CMD_START, 16'sd0);
      send_spin_item(CMD_SAMPLE, -16'sd2000);
      send_spin_item(CMD_SAMPLE, -16'sd3000);
   endtask

   // Out-of-range yaw wraps only once; a negative half-turn change is kept.
   task automatic test_wrap_once();
      send_spin_item(CMD_START, -16'sd32768);
      send_spin_item(CMD_SAMPLE, 16'sd32767);
      send_spin_item(CMD_SAMPLE, -16'sd32768);
      send_spin_item(CMD_START, 16'sd18000);
      send_spin_item(CMD_SAMPLE, 16'sd0);
   endtask

   // Zero stop angle, full below min, and an empty up ramp.
   task automatic test_profile_extremes();
      apply_profile(10000, 0, 0, 0, 0);
      send_spin_item(CMD_START, 16'sd0);
      send_spin_item(CMD_SAMPLE, 16'sd0);
      apply_profile(0, 10000, 36000, 35999, 36000);
      send_spin_item(CMD_START, 16'sd0);
      send_spin_item(CMD_SAMPLE, 16'sd9000);
      send_spin_item(CMD_SAMPLE, 16'sd18000);
      apply_profile(10000, 10000, 0, 100, 36000);
      send_spin_item(CMD_START, 16'sd0);
      send_spin_item(CMD_SAMPLE, 16'sd50);
      send_spin_item(CMD_SAMPLE, 16'sd150);
   endtask

   // Mostly complete spins with random steps, some noise and broken spins.
   task automatic run_random_spins(input int n_items);
      int sent, next_profile, yaw, step, max_step, k;
      bit neg_dir;
      sent         = 0;
      next_profile = 0;
      while (sent < n_items) begin
         if (sent >= next_profile) begin
            random_profile();
            next_profile = sent + 60;
         end
         case ($urandom_range(9))
            0: begin
               // raw 16-bit yaw, either command
               send_spin_item(logic'($urandom_range(1)), 16'($urandom_range(0, 65535)));
               sent++;
            end
            1: begin
               send_spin_item(CMD_SAMPLE, 16'(int'($urandom_range(0, 36000)) - 18000));
               sent++;
            end
            default: begin
               yaw = int'($urandom_range(0, 36000)) - 18000;
               send_spin_item(CMD_START, 16'(yaw));
               sent++;
               max_step = int'(prof_stop) / 6 + 50;
               if (max_step > 18000)
                  max_step = 18000;
               neg_dir = $urandom_range(1);
               for (k = 0; k < 80 && spin_armed; k++) begin
                  step = $urandom_range(1, max_step);
                  if ($urandom_range(14) == 0)
                     step = -step;
                  yaw += neg_dir ? -step : step;
                  if (yaw > 18000)
                     yaw -= 36000;
                  else if (yaw < -18000)
                     yaw += 36000;
                  if ($urandom_range(29) == 0)
                     yaw = int'($urandom_range(0, 36000)) - 18000;
                  // abandon the spin now and then; the next start rearms mid-turn
                  if ($urandom_range(39) == 0)
                     break;
                  send_spin_item(CMD_SAMPLE, 16'(yaw));
                  sent++;
               end
            end
         endcase
      end
   endtask

   // Hold the receiver off for a long stretch while the sender keeps offering
   // a slow spin, so the block fills up and stalls its input.
   task automatic test_backpressure();
      int saved_pct, k;
      apply_profile(2500, 800, 3000, 30000, 35800);
      saved_pct     = send_idle_pct;
      send_idle_pct = 0;
      hold_epoch   <= hold_epoch + 1;
      send_spin_item(CMD_START, 16'sd0);
      for (k = 1; k <= 40; k++)
         send_spin_item(CMD_SAMPLE, 16'(k * 100));
      send_idle_pct = saved_pct;
      drain();
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct  = 20;
      recv_idle_pct <= 79;
      test_reset_profile();
      test_down_ramp();
      test_wrap_once();
      test_profile_extremes();
      run_random_spins(350);
      test_backpressure();

      send_idle_pct  = 79;
      recv_idle_pct <= 20;
      run_random_spins(350);

      send_idle_pct  = 0;
      recv_idle_pct <= 0;
      run_random_spins(350);

      drain();
      if (fail_count == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin
      #(5_000_000);
      $display("FAILED: results differ");
      $finish;
   end

endmodule

@@ filelist.f @@
sv/stp_pkg.sv
sv/stp_ctrl.sv
sv/stp_datapath.sv
sv/spin_trapezoid_profile.sv
sv/stp_checker.sv
dv/spin_trapezoid_profile_tb.sv
